@@ rtl/core/pttbl_pkg.sv @@
// Shared types and constants for the push-to-talk latch and timeout block.
`timescale 1ns / 1ps
`default_nettype none

package pttbl_pkg;

  // Fixed field widths
  localparam int unsigned NOW_W  = 32;
  localparam int unsigned TMO_W  = 26;  // widest timeout in ms: 65535 * 1000
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 4;

  localparam logic [TMO_W-1:0] DEFAULT_TIMEOUT_MS = TMO_W'(300000);
  localparam logic [9:0]       MS_PER_SECOND      = 10'd1000;

  // Register reset values
  localparam logic [15:0] TIMEOUT_SECONDS_RST      = 16'd0;
  localparam logic [7:0]  DEBOUNCE_MS_RST          = 8'd30;
  localparam logic [15:0] LONG_PRESS_MS_RST        = 16'd500;
  localparam logic [7:0]  MIN_POLL_INTERVAL_MS_RST = 8'd15;

  typedef enum logic [1:0] {
    REG_TIMEOUT_SECONDS      = 2'd0,
    REG_DEBOUNCE_MS          = 2'd1,
    REG_LONG_PRESS_MS        = 2'd2,
    REG_MIN_POLL_INTERVAL_MS = 2'd3
  } reg_idx_t;

  typedef enum logic {
    FUNC_POLL      = 1'b0,
    FUNC_SOFT_HOLD = 1'b1
  } func_t;

  typedef struct packed {
    logic             func;
    logic [NOW_W-1:0] now_ms;
    logic             button_level;
    logic             soft_held;
  } item_t;

  typedef struct packed {
    logic tx_active;
    logic button_pressed;
    logic timeout_fired;
    logic poll_taken;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/ptt_button_latch_timeout.sv @@
// Push-to-talk controller: debounce, tap latch, momentary hold and transmit timeout.
//
// Usage
//   item channel (item_valid / item_ready / item): one transfer is either a poll
//   tick carrying a millisecond timestamp and the raw active-low button level,
//   or a soft-hold request. Every item yields exactly one result transfer.
//   result channel (result_valid / result_ready / result): transmit state,
//   debounced button state, a timeout flag and a flag for a poll that passed
//   the minimum poll interval.
//   APB port: four registers at byte offsets 0, 4, 8, 12 (timeout seconds,
//   debounce ms, long-press ms, minimum poll interval ms); write only while idle.
// Timing
//   An item is captured in the input stage, then evaluated and written to the
//   result register. One item per cycle is sustained while the receiver takes
//   results; the single-pass update of the state registers sets that figure.
// Reset and stalls
//   rst (synchronous) empties both stages, restores the register defaults and
//   returns the controller to released, transmit off, no poll seen. When the
//   receiver stalls, the result register holds, the input stage fills, and
//   item_ready drops only once both are occupied.
`timescale 1ns / 1ps
`default_nettype none

module ptt_button_latch_timeout
  import pttbl_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // item channel
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire item_t             item,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result,
  // configuration port
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int unsigned CMP_W = (TIME_WIDTH > TMO_W) ? TIME_WIDTH : TMO_W;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0]      timeout_seconds;
  logic [TMO_W-1:0] timeout_ms;       // precomputed at write time
  logic [7:0]       debounce_ms;
  logic [15:0]      long_press_ms;
  logic [7:0]       min_poll_interval_ms;

  logic             cfg_write;
  reg_idx_t         cfg_idx;
  logic [TMO_W-1:0] timeout_ms_next;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_idx   = reg_idx_t'(paddr[3:2]);

  // Zero seconds selects the default timeout.
  always_comb begin
    if (pwdata[15:0] == 16'd0) begin
      timeout_ms_next = DEFAULT_TIMEOUT_MS;
    end else begin
      timeout_ms_next = TMO_W'(pwdata[15:0]) * TMO_W'(MS_PER_SECOND);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_seconds      <= TIMEOUT_SECONDS_RST;
      timeout_ms           <= DEFAULT_TIMEOUT_MS;
      debounce_ms          <= DEBOUNCE_MS_RST;
      long_press_ms        <= LONG_PRESS_MS_RST;
      min_poll_interval_ms <= MIN_POLL_INTERVAL_MS_RST;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        REG_TIMEOUT_SECONDS: begin
          timeout_seconds <= pwdata[15:0];
          timeout_ms      <= timeout_ms_next;
        end
        REG_DEBOUNCE_MS:          debounce_ms          <= pwdata[7:0];
        REG_LONG_PRESS_MS:        long_press_ms        <= pwdata[15:0];
        REG_MIN_POLL_INTERVAL_MS: min_poll_interval_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TIMEOUT_SECONDS:      prdata = DATA_W'(timeout_seconds);
      REG_DEBOUNCE_MS:          prdata = DATA_W'(debounce_ms);
      REG_LONG_PRESS_MS:        prdata = DATA_W'(long_press_ms);
      REG_MIN_POLL_INTERVAL_MS: prdata = DATA_W'(min_poll_interval_ms);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input stage and result register handshake
  // ---------------------------------------------------------------------------
  logic  stage_valid;
  item_t stage_item;
  logic  advance;
  logic  update;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !stage_valid || advance;
  assign update     = stage_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  // ---------------------------------------------------------------------------
  // Controller state
  // ---------------------------------------------------------------------------
  logic  sampled_level;
  logic  debounced_pressed;
  time_t level_changed_time;
  time_t press_start_time;
  logic  tx_latched;
  logic  tx_suppressed;
  logic  tx_on;
  logic  soft_hold;
  time_t tx_start_time;
  time_t last_poll_time;
  logic  poll_seen;

  logic  sampled_level_next;
  logic  debounced_pressed_next;
  time_t level_changed_time_next;
  time_t press_start_time_next;
  logic  tx_latched_next;
  logic  tx_suppressed_next;
  logic  tx_on_next;
  logic  soft_hold_next;
  time_t tx_start_time_next;
  time_t last_poll_time_next;
  logic  poll_seen_next;
  result_t result_next;

  // Timestamp folded to the internal time range.
  logic [TIME_WIDTH+NOW_W-1:0] now_ext;
  time_t now;
  time_t since_poll;
  time_t since_change;
  time_t since_press;
  time_t since_tx;
  logic  gate_open;
  logic  level_pressed;
  logic  tx_want;
  logic  fire;

  assign now_ext      = {TIME_WIDTH'(0), stage_item.now_ms};
  assign now          = now_ext[TIME_WIDTH-1:0];
  assign since_poll   = now - last_poll_time;
  assign since_change = now - level_changed_time;
  assign since_press  = now - press_start_time;
  assign since_tx     = now - tx_start_time;
  assign gate_open    = !poll_seen || (since_poll >= TIME_WIDTH'(min_poll_interval_ms));
  assign level_pressed = !stage_item.button_level;

  always_comb begin
    sampled_level_next      = sampled_level;
    debounced_pressed_next  = debounced_pressed;
    level_changed_time_next = level_changed_time;
    press_start_time_next   = press_start_time;
    tx_latched_next         = tx_latched;
    tx_suppressed_next      = tx_suppressed;
    tx_on_next              = tx_on;
    soft_hold_next          = soft_hold;
    tx_start_time_next      = tx_start_time;
    last_poll_time_next     = last_poll_time;
    poll_seen_next          = poll_seen;
    tx_want                 = 1'b0;
    fire                    = 1'b0;
    result_next.poll_taken  = 1'b0;

    if (stage_item.func == FUNC_SOFT_HOLD) begin
      // Releasing the soft hold lifts a timeout suppression.
      soft_hold_next = stage_item.soft_held;
      if (!stage_item.soft_held) begin
        tx_suppressed_next = 1'b0;
      end
    end else if (gate_open) begin
      result_next.poll_taken = 1'b1;
      poll_seen_next         = 1'b1;
      last_poll_time_next    = now;

      // Debounce: restart the stability window on any raw change.
      if (stage_item.button_level != sampled_level) begin
        sampled_level_next      = stage_item.button_level;
        level_changed_time_next = now;
      end else if (level_pressed != debounced_pressed &&
                   since_change >= TIME_WIDTH'(debounce_ms)) begin
        debounced_pressed_next = level_pressed;
      end

      // Press edge: note start; release edge: tap toggles, long or suppressed press drops.
      if (debounced_pressed_next && !debounced_pressed) begin
        press_start_time_next = now;
        tx_suppressed_next    = 1'b0;
      end else if (!debounced_pressed_next && debounced_pressed) begin
        if (!tx_suppressed && since_press < TIME_WIDTH'(long_press_ms)) begin
          tx_latched_next = !tx_latched;
        end else begin
          tx_latched_next = 1'b0;
        end
        tx_suppressed_next = 1'b0;
      end

      tx_want = ((debounced_pressed_next || soft_hold) && !tx_suppressed_next) ||
                tx_latched_next;

      // A fresh key-up restarts the timer; elapsed is then zero and the
      // timeout is never zero, so only a running transmit can expire.
      if (tx_want && !tx_on) begin
        tx_start_time_next = now;
      end
      fire = tx_want && tx_on &&
             (CMP_W'(since_tx) >= CMP_W'(timeout_ms));
      if (fire) begin
        tx_latched_next    = 1'b0;
        tx_suppressed_next = 1'b1;
      end
      tx_on_next = tx_want && !fire;
    end

    result_next.tx_active      = tx_on_next;
    result_next.button_pressed = debounced_pressed_next;
    result_next.timeout_fired  = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sampled_level      <= 1'b1;
      debounced_pressed  <= 1'b0;
      level_changed_time <= '0;
      press_start_time   <= '0;
      tx_latched         <= 1'b0;
      tx_suppressed      <= 1'b0;
      tx_on              <= 1'b0;
      soft_hold          <= 1'b0;
      tx_start_time      <= '0;
      last_poll_time     <= '0;
      poll_seen          <= 1'b0;
    end else if (update) begin
      sampled_level      <= sampled_level_next;
      debounced_pressed  <= debounced_pressed_next;
      level_changed_time <= level_changed_time_next;
      press_start_time   <= press_start_time_next;
      tx_latched         <= tx_latched_next;
      tx_suppressed      <= tx_suppressed_next;
      tx_on              <= tx_on_next;
      soft_hold          <= soft_hold_next;
      tx_start_time      <= tx_start_time_next;
      last_poll_time     <= last_poll_time_next;
      poll_seen          <= poll_seen_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      result <= result_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A suppressed key can neither transmit nor hold the latch.
  a_suppress_blocks_tx: assert property (@(posedge clk) disable iff (rst)
    tx_suppressed |-> (!tx_on && !tx_latched))
    else $error("suppressed state with transmit or latch set");

  // A timeout only comes from a taken poll and always leaves transmit off.
  a_fire_is_poll: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.timeout_fired) |-> (result.poll_taken && !result.tx_active))
    else $error("timeout flag without taken poll or with transmit on");

  // A soft-hold item produces a result that never claims a poll.
  a_soft_hold_no_poll: assert property (@(posedge clk) disable iff (rst)
    (update && stage_item.func == FUNC_SOFT_HOLD) |=>
      (result_valid && !result.poll_taken && !result.timeout_fired))
    else $error("soft-hold item reported as poll");

  // Back-pressure only when both stages are occupied and the output stalls.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (stage_valid && result_valid && !result_ready))
    else $error("item_ready low with room in the pipeline");

endmodule

`default_nettype wire

@@ test/tb_ptt_button_latch_timeout.sv @@
// Self-checking testbench for the push-to-talk latch and transmit timeout controller.
`timescale 1ns / 1ps

module tb_ptt_button_latch_timeout;
  import pttbl_pkg::*;

  localparam int unsigned RUN_LIMIT   = 400000;  // cycles before the run is declared hung
  localparam logic [31:0] STD_TMO_MS  = 32'd300000;
  localparam logic [31:0] MS_PER_SEC  = 32'd1000;
  localparam int          PRINT_LIMIT = 40;

  // Clock, reset and DUT ports; every input starts at a known value
  logic              clk;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  item_t             item_data    = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  result_t           result_data;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [ADDR_W-1:0] paddr        = '0;
  logic [DATA_W-1:0] pwdata       = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ptt_button_latch_timeout uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_data),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Controller shadow: settings and state mirrored from what the DUT was given
  // ---------------------------------------------------------------------------
  logic [15:0] cfg_tmo_s;
  logic [7:0]  cfg_debounce;
  logic [15:0] cfg_long_ms;
  logic [7:0]  cfg_min_poll;

  logic        raw_lvl;
  logic        deb_pressed;
  logic [31:0] lvl_change_t;
  logic [31:0] press_t0;
  logic        latch_on;
  logic        suppress;
  logic        tx_state;
  logic        soft_on;
  logic [31:0] tx_t0;
  logic [31:0] last_poll_t;
  logic        poll_seen;

  item_t   item_q[$];     // items waiting to be sent
  result_t status_q[$];   // transmit status words still owed by the DUT

  int          num_errors = 0;
  int          num_results = 0;
  int          n_queued = 0;
  int unsigned cycles = 0;
  logic [31:0] clock_ms;  // running timestamp for generated polls

  task automatic shadow_reset();
    cfg_tmo_s    = TIMEOUT_SECONDS_RST;
    cfg_debounce = DEBOUNCE_MS_RST;
    cfg_long_ms  = LONG_PRESS_MS_RST;
    cfg_min_poll = MIN_POLL_INTERVAL_MS_RST;
    raw_lvl      = 1'b1;
    deb_pressed  = 1'b0;
    lvl_change_t = '0;
    press_t0     = '0;
    latch_on     = 1'b0;
    suppress     = 1'b0;
    tx_state     = 1'b0;
    soft_on      = 1'b0;
    tx_t0        = '0;
    last_poll_t  = '0;
    poll_seen    = 1'b0;
  endtask

  // Transmit auto-off time in ms; zero seconds selects the standard five minutes
  function automatic logic [31:0] hold_limit_ms();
    return (cfg_tmo_s != 16'd0) ? 32'(cfg_tmo_s) * MS_PER_SEC : STD_TMO_MS;
  endfunction

  // Advance the shadow by one accepted item and return the status it should produce
  function automatic result_t ptt_next_status(item_t it);
    result_t     r;
    logic        was;
    logic        txn;
    logic        fired;
    logic        taken;
    logic [31:0] now;
    fired = 1'b0;
    taken = 1'b0;
    now   = it.now_ms;
    if (it.func == FUNC_SOFT_HOLD) begin
      // Soft hold only takes effect at the next accepted poll
      soft_on = it.soft_held;
      if (!it.soft_held)
        suppress = 1'b0;
    end else if (!poll_seen || (now - last_poll_t) >= 32'(cfg_min_poll)) begin
      taken       = 1'b1;
      poll_seen   = 1'b1;
      last_poll_t = now;
      was         = deb_pressed;
      // Debounce: a raw change restarts the stable window
      if (it.button_level != raw_lvl) begin
        raw_lvl      = it.button_level;
        lvl_change_t = now;
      end else if ((!it.button_level) != deb_pressed &&
                   (now - lvl_change_t) >= 32'(cfg_debounce)) begin
        deb_pressed = !it.button_level;
      end
      if (deb_pressed && !was) begin
        press_t0 = now;
        suppress = 1'b0;
      end else if (!deb_pressed && was) begin
        // Short tap toggles the latch, a long or suppressed press drops it
        if (!suppress && (now - press_t0) < 32'(cfg_long_ms))
          latch_on = !latch_on;
        else
          latch_on = 1'b0;
        suppress = 1'b0;
      end
      txn = ((deb_pressed || soft_on) && !suppress) || latch_on;
      if (txn && !tx_state)
        tx_t0 = now;
      if (txn && (now - tx_t0) >= hold_limit_ms()) begin
        latch_on = 1'b0;
        suppress = 1'b1;
        txn      = 1'b0;
        fired    = 1'b1;
      end
      tx_state = txn;
    end
    r.tx_active      = tx_state;
    r.button_pressed = deb_pressed;
    r.timeout_fired  = fired;
    r.poll_taken     = taken;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Error reporting
  // ---------------------------------------------------------------------------
  task automatic report_err(input string msg);
    num_errors++;
    if (num_errors <= PRINT_LIMIT)
      $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic got, input logic want);
    if (got !== want)
      report_err($sformatf("status %0d field %s: got %b, expected %b",
                           num_results, name, got, want));
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: bursts of random length with random gaps, fed from item_q
  // ---------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic  nv;
    item_t ni;
    nv = 1'b0;
    ni = item_data;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      // Record the prediction for the transfer completing at this edge
      if (item_valid && item_ready)
        status_q.push_back(ptt_next_status(item_data));
      if (item_valid && !item_ready) begin
        // Hold valid and payload until the transfer happens
        nv = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (item_q.size() > 0) begin
        ni = item_q.pop_front();
        nv = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      item_valid <= nv;
      item_data  <= ni;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest prediction
  // and stall the result side on its own segmented pattern
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  always @(posedge clk) begin
    result_t want;
    logic    nr;
    nr = 1'b1;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (status_q.size() == 0) begin
          report_err($sformatf("status %0d arrived with nothing outstanding", num_results));
        end else begin
          want = status_q.pop_front();
          check_field("tx_active", result_data.tx_active, want.tx_active);
          check_field("button_pressed", result_data.button_pressed, want.button_pressed);
          check_field("timeout_fired", result_data.timeout_fired, want.timeout_fired);
          check_field("poll_taken", result_data.poll_taken, want.poll_taken);
        end
        num_results++;
      end
      // Pick a new random stall behavior when the current segment runs out
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 96);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: nr = 1'b1;
        1: nr = ($urandom_range(0, 3) != 0);
        2: nr = ($urandom_range(0, 3) == 0);
        default: nr = ((stall_tick % 5) < 3);
      endcase
      result_ready <= nr;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= RUN_LIMIT) begin
      $display("[%0t] watchdog expired with %0d items and %0d statuses pending",
               $realtime, item_q.size(), status_q.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_poll(input logic lvl, input logic [31:0] dt);
    item_t it;
    clock_ms        = clock_ms + dt;
    it.func         = FUNC_POLL;
    it.now_ms       = clock_ms;
    it.button_level = lvl;
    it.soft_held    = 1'($urandom_range(0, 1));  // unused on a poll, randomized anyway
    item_q.push_back(it);
    n_queued++;
  endtask

  task automatic add_soft(input logic held);
    item_t it;
    it.func         = FUNC_SOFT_HOLD;
    it.now_ms       = $urandom;
    it.button_level = 1'($urandom_range(0, 1));
    it.soft_held    = held;
    item_q.push_back(it);
    n_queued++;
  endtask

  // One random button gesture, scaled to the current settings
  task automatic add_gesture();
    logic [31:0] step;
    logic [31:0] dt;
    int          n;
    step = 32'(cfg_min_poll) + 32'(cfg_debounce) + $urandom_range(1, 20);
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        // Short tap, sometimes with contact bounce at the start
        if ($urandom_range(0, 2) == 0) begin
          add_poll(1'b0, $urandom_range(0, 40));
          add_poll(1'b1, $urandom_range(0, 40));
        end
        n = $urandom_range(2, 4);
        repeat (n) add_poll(1'b0, step);
        n = $urandom_range(2, 3);
        repeat (n) add_poll(1'b1, step);
      end
      3, 4: begin
        // Press held past the long-press time
        dt = (32'(cfg_long_ms) >> 1) + step;
        n  = $urandom_range(3, 5);
        repeat (n) add_poll(1'b0, dt);
        repeat (2) add_poll(1'b1, step);
      end
      5: begin
        // Press held past the transmit timeout
        dt = (hold_limit_ms() >> 1) + step;
        n  = $urandom_range(3, 4);
        repeat (n) add_poll(1'b0, dt);
        repeat (2) add_poll(1'b1, step);
      end
      6: begin
        // Soft hold, possibly outlasting the timeout, usually released
        add_soft(1'b1);
        n = $urandom_range(1, 4);
        repeat (n) add_poll(1'($urandom_range(0, 1)),
                            ($urandom_range(0, 1) != 0) ? (hold_limit_ms() >> 1) + step : step);
        if ($urandom_range(0, 3) != 0)
          add_soft(1'b0);
        add_poll(1'b1, step);
      end
      7: begin
        // Noise: random levels at random spacing
        n = $urandom_range(3, 6);
        repeat (n) add_poll(1'($urandom_range(0, 1)), $urandom_range(0, 2 * step));
      end
      8: begin
        // Arbitrary jump, wrapping the timestamp anywhere
        add_poll(1'($urandom_range(0, 1)), $urandom);
      end
      default: begin
        // Crowded polls: mostly inside the interval and dropped, so not counted
        n = $urandom_range(2, 5);
        repeat (n) add_poll(1'($urandom_range(0, 1)), $urandom_range(0, cfg_min_poll));
        n_queued -= n;
      end
    endcase
  endtask

  task automatic add_random(input int count);
    int goal;
    goal = n_queued + count;
    while (n_queued < goal)
      add_gesture();
  endtask

  // Wait until nothing is in flight, then let the pipeline drain
  task automatic wait_idle();
    while (item_q.size() != 0 || item_valid || status_q.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write with setup and access cycles, then read back
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] want;
    case (idx)
      REG_TIMEOUT_SECONDS:      want = {16'd0, val[15:0]};
      REG_DEBOUNCE_MS:          want = {24'd0, val[7:0]};
      REG_LONG_PRESS_MS:        want = {16'd0, val[15:0]};
      default:                  want = {24'd0, val[7:0]};
    endcase
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // The register takes the value at this edge; mirror it in the shadow
    case (idx)
      REG_TIMEOUT_SECONDS:      cfg_tmo_s    = val[15:0];
      REG_DEBOUNCE_MS:          cfg_debounce = val[7:0];
      REG_LONG_PRESS_MS:        cfg_long_ms  = val[15:0];
      default:                  cfg_min_poll = val[7:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want)
      report_err($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] tmo_s, input logic [7:0] dbn,
                           input logic [15:0] lng, input logic [7:0] minp);
    write_reg(REG_TIMEOUT_SECONDS, 32'(tmo_s));
    write_reg(REG_DEBOUNCE_MS, 32'(dbn));
    write_reg(REG_LONG_PRESS_MS, 32'(lng));
    write_reg(REG_MIN_POLL_INTERVAL_MS, 32'(minp));
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    shadow_reset();
    clock_ms = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings
    add_poll(1'b1, 32'd3);          // first poll passes even inside the interval
    add_poll(1'b1, 32'd7);          // too soon: dropped
    add_poll(1'b0, 32'd8);          // raw press seen
    add_poll(1'b0, 32'd40);         // stable long enough: debounced press
    add_poll(1'b1, 32'd100);        // raw release
    add_poll(1'b1, 32'd40);         // tap completes: latch transmit on
    add_soft(1'b1);
    add_poll(1'b1, STD_TMO_MS);     // latched transmit runs out: timeout
    add_poll(1'b1, 32'd20);         // soft hold stays suppressed
    add_soft(1'b0);                 // release clears the suppression
    add_poll(1'b1, 32'd20);
    add_poll(1'b0, 32'd20);         // long press: momentary only
    add_poll(1'b0, 32'd40);
    add_poll(1'b0, 32'd600);
    add_poll(1'b1, 32'd20);
    add_poll(1'b1, 32'd40);
    clock_ms = 32'hFFFF_FFFF;       // timestamp at all ones, then wrap through zero
    add_poll(1'b1, 32'd0);
    add_poll(1'b0, 32'd1);
    add_poll(1'b0, 32'd40);
    add_poll(1'b0, STD_TMO_MS);     // debounced press: transmit starts, no timeout yet
    add_poll(1'b0, 32'd20);
    add_poll(1'b1, 32'd20);         // raw release; the next poll completes a tap that latches transmit on
    add_poll(1'b1, 32'd40);
    wait_idle();

    add_random(170);
    wait_idle();

    // Lower extremes: one-second timeout, no debounce, no long-press, no interval
    write_all(16'd1, 8'd0, 16'd0, 8'd0);
    add_random(170);
    wait_idle();

    // Upper extremes
    write_all(16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    add_random(170);
    wait_idle();

    // Default timeout with random timing
    write_all(16'd0, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 2000)),
              8'($urandom_range(0, 255)));
    add_random(170);
    wait_idle();

    // Short timeouts and random timing
    write_all(16'($urandom_range(1, 10)), 8'($urandom_range(0, 255)),
              16'($urandom), 8'($urandom_range(0, 255)));
    add_random(170);
    wait_idle();

    write_all(16'd2, 8'd5, 16'd300, 8'd1);
    add_random(170);
    wait_idle();

    repeat (10) @(posedge clk);
    if (num_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pttbl_pkg.sv
rtl/core/ptt_button_latch_timeout.sv
test/tb_ptt_button_latch_timeout.sv
